@@ rtl/ttcp_pkg.sv @@
`default_nettype none

package ttcp_pkg;

  // Field widths of the token and result beats.
  localparam int TOKEN_W = 6;
  localparam int ROW_W   = 16;
  localparam int COL_W   = 6;
  localparam int SPAN_W  = 5;
  localparam int CNT_W   = 16;

  // Defaults for the top-level parameters.
  localparam int MAX_COLS_DEF = 64;
  localparam int MAX_SPAN_DEF = 20;

  localparam logic [CNT_W-1:0] CNT_MAX     = '1;
  localparam logic [COL_W-1:0] COL_OUT_MAX = '1;

  // Structure vocabulary.
  localparam logic [TOKEN_W-1:0] TOK_ROW_END      = 6'd6;
  localparam logic [TOKEN_W-1:0] TOK_CELL_OPEN    = 6'd7;
  localparam logic [TOKEN_W-1:0] TOK_ATTR_CLOSE   = 6'd8;
  localparam logic [TOKEN_W-1:0] TOK_CELL_END     = 6'd9;
  localparam logic [TOKEN_W-1:0] TOK_COLSPAN_LO   = 6'd10;
  localparam logic [TOKEN_W-1:0] TOK_COLSPAN_HI   = 6'd28;
  localparam logic [TOKEN_W-1:0] TOK_COLSPAN_BIAS = 6'd8;
  localparam logic [TOKEN_W-1:0] TOK_ROWSPAN_LO   = 6'd29;
  localparam logic [TOKEN_W-1:0] TOK_ROWSPAN_HI   = 6'd47;
  localparam logic [TOKEN_W-1:0] TOK_ROWSPAN_BIAS = 6'd27;
  localparam logic [TOKEN_W-1:0] TOK_EMPTY_CELL   = 6'd48;
  localparam logic [TOKEN_W-1:0] TOK_END          = 6'd49;
  localparam logic [TOKEN_W-1:0] VOCAB_SIZE       = 6'd50;

  // Result kinds.
  localparam logic KIND_CELL = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [ROW_W-1:0]  cell_row;
    logic [COL_W-1:0]  cell_col;
    logic [SPAN_W-1:0] row_span;
    logic [SPAN_W-1:0] col_span;
    logic [CNT_W-1:0]  box_index;
    logic [CNT_W-1:0]  cell_total;
    logic              col_overflow;
    logic              final_res;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/ttcp_if.sv @@
`default_nettype none

interface ttcp_tok_if;
  logic                         valid;
  logic                         ready;
  logic [ttcp_pkg::TOKEN_W-1:0] token;
  logic                         last;

  modport source (output valid, output token, output last, input ready);
  modport sink   (input valid, input token, input last, output ready);
endinterface

interface ttcp_res_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [ttcp_pkg::ROW_W-1:0]  cell_row;
  logic [ttcp_pkg::COL_W-1:0]  cell_col;
  logic [ttcp_pkg::SPAN_W-1:0] row_span;
  logic [ttcp_pkg::SPAN_W-1:0] col_span;
  logic [ttcp_pkg::CNT_W-1:0]  box_index;
  logic [ttcp_pkg::CNT_W-1:0]  cell_total;
  logic                        col_overflow;
  logic                        final_res;

  modport source (output valid, output kind, output cell_row, output cell_col,
                  output row_span, output col_span, output box_index,
                  output cell_total, output col_overflow, output final_res,
                  input ready);
  modport sink   (input valid, input kind, input cell_row, input cell_col,
                  input row_span, input col_span, input box_index,
                  input cell_total, input col_overflow, input final_res,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/ttcp_held_mem.sv @@
`default_nettype none

module ttcp_held_mem #(
  parameter int MAX_COLS = ttcp_pkg::MAX_COLS_DEF,
  localparam int AW = $clog2(MAX_COLS)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        clr_i,
  input  wire logic                        rd_en_i,
  input  wire logic [AW-1:0]               rd_addr_i,
  output      logic [ttcp_pkg::SPAN_W-1:0] rd_data_o,
  input  wire logic                        wr_en_i,
  input  wire logic [AW-1:0]               wr_addr_i,
  input  wire logic [ttcp_pkg::SPAN_W-1:0] wr_data_i
);

  logic [ttcp_pkg::SPAN_W-1:0] mem [MAX_COLS];
  logic [MAX_COLS-1:0]         vld_q;
  logic [ttcp_pkg::SPAN_W-1:0] rd_q;
  logic                        rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q     <= mem[rd_addr_i];
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  // A column never written since the last clear counts as not held.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clr_i) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

@@ rtl/ttcp_out_reg.sv @@
`default_nettype none

module ttcp_out_reg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_valid_i,
  output      logic           load_ready_o,
  input  wire ttcp_pkg::res_t load_data_i,
  ttcp_res_if.source          res_o
);

  logic           full_q, full_d;
  ttcp_pkg::res_t data_q;

  assign load_ready_o = !full_q || res_o.ready;

  always_comb begin
    full_d = full_q;
    if (load_valid_i && load_ready_o) begin
      full_d = 1'b1;
    end else if (res_o.ready) begin
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_valid_i && load_ready_o) begin
      data_q <= load_data_i;
    end
  end

  assign res_o.valid        = full_q;
  assign res_o.kind         = data_q.kind;
  assign res_o.cell_row     = data_q.cell_row;
  assign res_o.cell_col     = data_q.cell_col;
  assign res_o.row_span     = data_q.row_span;
  assign res_o.col_span     = data_q.col_span;
  assign res_o.box_index    = data_q.box_index;
  assign res_o.cell_total   = data_q.cell_total;
  assign res_o.col_overflow = data_q.col_overflow;
  assign res_o.final_res    = data_q.final_res;

endmodule

`default_nettype wire

@@ rtl/ttcp_ctrl.sv @@
`default_nettype none

module ttcp_ctrl #(
  parameter int MAX_COLS = ttcp_pkg::MAX_COLS_DEF,
  parameter int MAX_SPAN = ttcp_pkg::MAX_SPAN_DEF,
  localparam int AW = $clog2(MAX_COLS),
  localparam int CW = $clog2(MAX_COLS + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        box_per_step_i,
  ttcp_tok_if.sink                         tok_i,
  output      logic                        res_valid_o,
  input  wire logic                        res_ready_i,
  output      ttcp_pkg::res_t              res_o,
  output      logic                        mem_clr_o,
  output      logic                        mem_rd_en_o,
  output      logic [AW-1:0]               mem_rd_addr_o,
  input  wire logic [ttcp_pkg::SPAN_W-1:0] mem_rd_data_i,
  output      logic                        mem_wr_en_o,
  output      logic [AW-1:0]               mem_wr_addr_o,
  output      logic [ttcp_pkg::SPAN_W-1:0] mem_wr_data_o
);

  localparam int SW     = $clog2(MAX_COLS + MAX_SPAN + 1);
  localparam int TW     = ttcp_pkg::TOKEN_W;
  localparam int PW     = ttcp_pkg::SPAN_W;
  localparam int NW     = ttcp_pkg::CNT_W;
  localparam int RW     = ttcp_pkg::ROW_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DEC     = 4'd1;
  localparam logic [3:0] S_SCAN_RD = 4'd2;
  localparam logic [3:0] S_SCAN_CK = 4'd3;
  localparam logic [3:0] S_FILL    = 4'd4;
  localparam logic [3:0] S_CELL    = 4'd5;
  localparam logic [3:0] S_END     = 4'd6;
  localparam logic [3:0] S_SWP_RD  = 4'd7;
  localparam logic [3:0] S_SWP_WR  = 4'd8;

  localparam logic [PW-1:0] SPAN_ONE = PW'(1);
  localparam logic [PW-1:0] SPAN_CAP = PW'(MAX_SPAN);

  logic [3:0]    state_q, state_d;
  logic [TW-1:0] tok_q, tok_d;
  logic          last_q, last_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic          open_q, open_d;
  logic [PW-1:0] pcs_q, pcs_d;
  logic [PW-1:0] prs_q, prs_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] step_q, step_d;
  logic          seen_q, seen_d;
  logic [NW-1:0] pos_q, pos_d;
  logic [PW-1:0] cur_rs_q, cur_rs_d;
  logic [PW-1:0] cur_cs_q, cur_cs_d;
  logic          end_q, end_d;
  logic [CW-1:0] start_q, start_d;
  logic [SW-1:0] stop_q, stop_d;
  logic [CW-1:0] ptr_q, ptr_d;

  // Token decode.
  logic          tok_ok, is_close, is_cs, is_rs;
  logic [TW-1:0] cs_raw, rs_raw;
  logic [PW-1:0] cs_val, rs_val;
  logic          dec_open, dec_place, dec_rowadv, dec_end;
  logic [PW-1:0] dec_pcs, dec_prs, dec_rs, dec_cs;

  logic [RW-1:0] start_ext;
  logic          ovf;

  assign tok_ok   = tok_q < ttcp_pkg::VOCAB_SIZE;
  assign is_close = (tok_q == ttcp_pkg::TOK_ATTR_CLOSE) || (tok_q == ttcp_pkg::TOK_CELL_END);
  assign is_cs    = (tok_q >= ttcp_pkg::TOK_COLSPAN_LO) && (tok_q <= ttcp_pkg::TOK_COLSPAN_HI);
  assign is_rs    = (tok_q >= ttcp_pkg::TOK_ROWSPAN_LO) && (tok_q <= ttcp_pkg::TOK_ROWSPAN_HI);
  assign cs_raw   = tok_q - ttcp_pkg::TOK_COLSPAN_BIAS;
  assign rs_raw   = tok_q - ttcp_pkg::TOK_ROWSPAN_BIAS;
  assign cs_val   = (cs_raw > TW'(MAX_SPAN)) ? SPAN_CAP : cs_raw[PW-1:0];
  assign rs_val   = (rs_raw > TW'(MAX_SPAN)) ? SPAN_CAP : rs_raw[PW-1:0];
  assign dec_end  = (tok_q == ttcp_pkg::TOK_END) || last_q;

  always_comb begin
    dec_open   = open_q;
    dec_pcs    = pcs_q;
    dec_prs    = prs_q;
    dec_place  = 1'b0;
    dec_rs     = prs_q;
    dec_cs     = pcs_q;
    dec_rowadv = 1'b0;
    if (tok_ok && open_q) begin
      if (is_close) begin
        dec_place = 1'b1;
        dec_open  = 1'b0;
        dec_pcs   = SPAN_ONE;
        dec_prs   = SPAN_ONE;
      end else if (is_cs) begin
        dec_pcs = cs_val;
      end else if (is_rs) begin
        dec_prs = rs_val;
      end
    end else if (tok_ok && tok_q == ttcp_pkg::TOK_ROW_END) begin
      dec_rowadv = !dec_end;
    end else if (tok_ok && tok_q == ttcp_pkg::TOK_CELL_OPEN) begin
      dec_open = 1'b1;
      dec_pcs  = SPAN_ONE;
      dec_prs  = SPAN_ONE;
    end else if (tok_ok && tok_q == ttcp_pkg::TOK_EMPTY_CELL) begin
      dec_place = 1'b1;
      dec_rs    = SPAN_ONE;
      dec_cs    = SPAN_ONE;
    end
    // A cell still open at the end of the table is closed with its pending spans.
    if (dec_end && dec_open) begin
      dec_place = 1'b1;
      dec_rs    = dec_prs;
      dec_cs    = dec_pcs;
    end
  end

  assign tok_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    tok_d         = tok_q;
    last_d        = last_q;
    row_d         = row_q;
    col_d         = col_q;
    open_d        = open_q;
    pcs_d         = pcs_q;
    prs_d         = prs_q;
    cnt_d         = cnt_q;
    step_d        = step_q;
    seen_d        = seen_q;
    pos_d         = pos_q;
    cur_rs_d      = cur_rs_q;
    cur_cs_d      = cur_cs_q;
    end_d         = end_q;
    start_d       = start_q;
    stop_d        = stop_q;
    ptr_d         = ptr_q;
    res_valid_o   = 1'b0;
    mem_clr_o     = 1'b0;
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = '0;
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = '0;
    mem_wr_data_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (tok_i.valid) begin
          tok_d   = tok_i.token;
          last_d  = tok_i.last;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (seen_q) begin
          if (last_q) begin
            seen_d = 1'b0;
          end
          state_d = S_IDLE;
        end else begin
          open_d   = dec_open;
          pcs_d    = dec_pcs;
          prs_d    = dec_prs;
          cur_rs_d = dec_rs;
          cur_cs_d = dec_cs;
          end_d    = dec_end;
          pos_d    = step_q;
          if (!dec_end && step_q != ttcp_pkg::CNT_MAX) begin
            step_d = step_q + NW'(1);
          end
          if (dec_place) begin
            state_d = S_SCAN_RD;
          end else if (dec_rowadv) begin
            ptr_d   = '0;
            state_d = S_SWP_RD;
          end else if (dec_end) begin
            state_d = S_END;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_SCAN_RD: begin
        if (col_q >= CW'(MAX_COLS)) begin
          start_d = col_q;
          stop_d  = SW'(col_q) + SW'(cur_cs_q);
          ptr_d   = col_q;
          state_d = S_FILL;
        end else begin
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = col_q[AW-1:0];
          state_d       = S_SCAN_CK;
        end
      end
      S_SCAN_CK: begin
        // Columns still covered by a row span from above are stepped over.
        if (mem_rd_data_i != '0) begin
          col_d   = col_q + CW'(1);
          state_d = S_SCAN_RD;
        end else begin
          start_d = col_q;
          stop_d  = SW'(col_q) + SW'(cur_cs_q);
          ptr_d   = col_q;
          state_d = S_FILL;
        end
      end
      S_FILL: begin
        if (SW'(ptr_q) < stop_q && ptr_q < CW'(MAX_COLS)) begin
          mem_wr_en_o   = 1'b1;
          mem_wr_addr_o = ptr_q[AW-1:0];
          mem_wr_data_o = (cur_rs_q > SPAN_ONE) ? cur_rs_q : '0;
          ptr_d         = ptr_q + CW'(1);
        end else begin
          col_d   = (stop_q > SW'(MAX_COLS)) ? CW'(MAX_COLS) : stop_q[CW-1:0];
          state_d = S_CELL;
        end
      end
      S_CELL: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          if (cnt_q != ttcp_pkg::CNT_MAX) begin
            cnt_d = cnt_q + NW'(1);
          end
          state_d = end_q ? S_END : S_IDLE;
        end
      end
      S_END: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          row_d     = '0;
          col_d     = '0;
          open_d    = 1'b0;
          pcs_d     = SPAN_ONE;
          prs_d     = SPAN_ONE;
          cnt_d     = '0;
          step_d    = '0;
          mem_clr_o = 1'b1;
          seen_d    = !last_q;
          state_d   = S_IDLE;
        end
      end
      S_SWP_RD: begin
        mem_rd_en_o   = 1'b1;
        mem_rd_addr_o = ptr_q[AW-1:0];
        state_d       = S_SWP_WR;
      end
      S_SWP_WR: begin
        if (mem_rd_data_i != '0) begin
          mem_wr_en_o   = 1'b1;
          mem_wr_addr_o = ptr_q[AW-1:0];
          mem_wr_data_o = mem_rd_data_i - PW'(1);
        end
        if (ptr_q == CW'(MAX_COLS - 1)) begin
          if (row_q != RW'(ttcp_pkg::CNT_MAX)) begin
            row_d = row_q + RW'(1);
          end
          col_d   = '0;
          state_d = S_IDLE;
        end else begin
          ptr_d   = ptr_q + CW'(1);
          state_d = S_SWP_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      tok_q    <= '0;
      last_q   <= 1'b0;
      row_q    <= '0;
      col_q    <= '0;
      open_q   <= 1'b0;
      pcs_q    <= SPAN_ONE;
      prs_q    <= SPAN_ONE;
      cnt_q    <= '0;
      step_q   <= '0;
      seen_q   <= 1'b0;
      pos_q    <= '0;
      cur_rs_q <= SPAN_ONE;
      cur_cs_q <= SPAN_ONE;
      end_q    <= 1'b0;
      start_q  <= '0;
      stop_q   <= '0;
      ptr_q    <= '0;
    end else begin
      state_q  <= state_d;
      tok_q    <= tok_d;
      last_q   <= last_d;
      row_q    <= row_d;
      col_q    <= col_d;
      open_q   <= open_d;
      pcs_q    <= pcs_d;
      prs_q    <= prs_d;
      cnt_q    <= cnt_d;
      step_q   <= step_d;
      seen_q   <= seen_d;
      pos_q    <= pos_d;
      cur_rs_q <= cur_rs_d;
      cur_cs_q <= cur_cs_d;
      end_q    <= end_d;
      start_q  <= start_d;
      stop_q   <= stop_d;
      ptr_q    <= ptr_d;
    end
  end

  assign start_ext = RW'(start_q);
  assign ovf       = (start_q >= CW'(MAX_COLS)) || (stop_q > SW'(MAX_COLS));

  always_comb begin
    if (state_q == S_END) begin
      res_o.kind         = ttcp_pkg::KIND_END;
      res_o.cell_row     = '0;
      res_o.cell_col     = '0;
      res_o.row_span     = SPAN_ONE;
      res_o.col_span     = SPAN_ONE;
      res_o.box_index    = '0;
      res_o.cell_total   = cnt_q;
      res_o.col_overflow = 1'b0;
      res_o.final_res    = 1'b1;
    end else begin
      res_o.kind         = ttcp_pkg::KIND_CELL;
      res_o.cell_row     = row_q;
      res_o.cell_col     = (start_ext > RW'(ttcp_pkg::COL_OUT_MAX)) ?
                           ttcp_pkg::COL_OUT_MAX : start_ext[ttcp_pkg::COL_W-1:0];
      res_o.row_span     = cur_rs_q;
      res_o.col_span     = cur_cs_q;
      res_o.box_index    = box_per_step_i ? pos_q : cnt_q;
      res_o.cell_total   = '0;
      res_o.col_overflow = ovf;
      // When the table ends on this token the end marker follows the cell.
      res_o.final_res    = !end_q;
    end
  end

endmodule

`default_nettype wire

@@ rtl/table_token_cell_placer_unit.sv @@
`default_nettype none

// Table token cell placer: takes one structure token per beat and places table cells on a
// grid, giving one beat per placed cell and an end-of-table beat with the cell total. The
// per-column row-span counts live in a single synchronous memory of MAX_COLS entries with a
// valid bit per entry, so reset and table end clear it at once and no clearing pass is run.
// A token is taken only while the sequencer is idle. Each token is accepted and then
// decoded. A placed cell then runs a column scan that steps over held columns, a read and a
// check per column, with no read once the scan runs past the tracked columns. It then makes
// span writes for the cell's columns (fewer where the cell reaches past the tracked columns)
// and hands the cell beat over; where the table ends an end beat is handed over after it.
// A row end walks every column through the one memory port, read then write.
// The result side has an output register, so a beat waiting there does not stop the next
// token being taken.
module table_token_cell_placer_unit #(
  parameter int MAX_COLS = ttcp_pkg::MAX_COLS_DEF,
  parameter int MAX_SPAN = ttcp_pkg::MAX_SPAN_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic  cfg_wdata_i,
  ttcp_tok_if.sink   tok_i,
  ttcp_res_if.source res_o
);

  localparam int AW = $clog2(MAX_COLS);
  localparam int CW = $clog2(MAX_COLS + 1);

  logic                        box_per_step_q, box_per_step_d;
  logic                        res_valid;
  logic                        res_ready;
  ttcp_pkg::res_t              res_data;
  logic                        mem_clr;
  logic                        mem_rd_en;
  logic [AW-1:0]               mem_rd_addr;
  logic [ttcp_pkg::SPAN_W-1:0] mem_rd_data;
  logic                        mem_wr_en;
  logic [AW-1:0]               mem_wr_addr;
  logic [ttcp_pkg::SPAN_W-1:0] mem_wr_data;

  assign box_per_step_d = cfg_we_i ? cfg_wdata_i : box_per_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_per_step_q <= 1'b1;
    end else begin
      box_per_step_q <= box_per_step_d;
    end
  end

  ttcp_ctrl #(
    .MAX_COLS (MAX_COLS),
    .MAX_SPAN (MAX_SPAN)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .box_per_step_i (box_per_step_q),
    .tok_i          (tok_i),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res_data),
    .mem_clr_o      (mem_clr),
    .mem_rd_en_o    (mem_rd_en),
    .mem_rd_addr_o  (mem_rd_addr),
    .mem_rd_data_i  (mem_rd_data),
    .mem_wr_en_o    (mem_wr_en),
    .mem_wr_addr_o  (mem_wr_addr),
    .mem_wr_data_o  (mem_wr_data)
  );

  ttcp_held_mem #(
    .MAX_COLS (MAX_COLS)
  ) u_held_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (mem_clr),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data)
  );

  ttcp_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (res_valid),
    .load_ready_o (res_ready),
    .load_data_i  (res_data),
    .res_o        (res_o)
  );

  // The sequencer never reads and writes the same column in one cycle.
  a_no_rw_same_col : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_rd_en && mem_wr_en && mem_rd_addr == mem_wr_addr))
    else $error("held memory read and written at the same column");

  // Table clear and a span write never coincide.
  a_no_clr_with_wr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_clr && mem_wr_en))
    else $error("held memory cleared while being written");

  // Every end beat handed over clears the span memory in the same cycle.
  a_end_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready && res_data.kind == ttcp_pkg::KIND_END) |-> mem_clr)
    else $error("end beat without span memory clear");

  // Only tracked columns are ever addressed.
  a_addr_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_wr_en || mem_rd_en) |->
      (CW'(mem_wr_addr) < CW'(MAX_COLS) && CW'(mem_rd_addr) < CW'(MAX_COLS)))
    else $error("held memory addressed beyond tracked columns");

  // No token is taken while the sequencer is still delivering a beat.
  a_no_take_while_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !tok_i.ready)
    else $error("token accepted while a result is pending");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
module tb_top;
  import ttcp_pkg::*;

  localparam int NCOLS         = MAX_COLS_DEF;
  localparam int SPAN_LIMIT    = MAX_SPAN_DEF;
  localparam int CYCLE_LIMIT   = 1000000;
  // A row end walks every column, a read then a write each; this leaves room for one to finish.
  localparam int SETTLE_CYCLES = 4 * NCOLS + 50;
  localparam int LONG_HOLD     = 800;
  localparam int HOLD_AT_BEAT  = 150;
  localparam int PHASE_ITEMS   = 380;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic cfg_wdata;

  ttcp_tok_if tok_bus ();
  ttcp_res_if res_bus ();

  table_token_cell_placer_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .tok_i       (tok_bus),
    .res_o       (res_bus)
  );

  class placement_checker;
    bit                box_per_step;
    logic [ROW_W-1:0]  row_pos;
    int unsigned       col_pos;
    logic [SPAN_W-1:0] rows_held [NCOLS];
    bit                cell_open;
    logic [SPAN_W-1:0] pend_col_span;
    logic [SPAN_W-1:0] pend_row_span;
    logic [CNT_W-1:0]  cell_count;
    logic [CNT_W-1:0]  step_count;
    bit                seen_end;
    res_t              beats_due [$];
    int unsigned       errors;

    function new();
      box_per_step = 1'b1;
      clear_grid();
      seen_end = 1'b0;
      errors   = 0;
    endfunction

    function void clear_grid();
      foreach (rows_held[c]) rows_held[c] = '0;
      row_pos       = '0;
      col_pos       = 0;
      cell_open     = 1'b0;
      pend_col_span = 1;
      pend_row_span = 1;
      cell_count    = '0;
      step_count    = '0;
    endfunction

    function logic [SPAN_W-1:0] clamp_span(logic [TOKEN_W-1:0] s);
      return (s > SPAN_LIMIT) ? SPAN_W'(SPAN_LIMIT) : s[SPAN_W-1:0];
    endfunction

    // Skips held columns, claims the spanned ones and builds the cell beat.
    function res_t place(logic [SPAN_W-1:0] rspan, logic [SPAN_W-1:0] cspan,
                         logic [CNT_W-1:0] pos);
      res_t        r;
      int unsigned start;
      int unsigned stop;
      int unsigned c;
      while (col_pos < NCOLS && rows_held[col_pos] != 0) col_pos++;
      start = col_pos;
      stop  = start + cspan;
      for (c = start; c < stop && c < NCOLS; c++) begin
        rows_held[c] = (rspan > 1) ? rspan : '0;
      end
      col_pos = (stop > NCOLS) ? NCOLS : stop;
      r              = '0;
      r.kind         = KIND_CELL;
      r.cell_row     = row_pos;
      r.cell_col     = (start > COL_OUT_MAX) ? COL_OUT_MAX : COL_W'(start);
      r.row_span     = rspan;
      r.col_span     = cspan;
      r.box_index    = box_per_step ? pos : cell_count;
      r.col_overflow = (start >= NCOLS) || (stop > NCOLS);
      if (cell_count != CNT_MAX) cell_count++;
      return r;
    endfunction

    function void note_token(logic [TOKEN_W-1:0] tok, bit is_last);
      res_t             placed;
      res_t             marker;
      bit               has_placed;
      logic [CNT_W-1:0] pos;
      int unsigned      c;
      has_placed = 1'b0;
      pos        = step_count;
      if (seen_end) begin
        if (is_last) seen_end = 1'b0;
        return;
      end
      if (tok < VOCAB_SIZE) begin
        if (cell_open) begin
          if (tok == TOK_ATTR_CLOSE || tok == TOK_CELL_END) begin
            placed        = place(pend_row_span, pend_col_span, pos);
            has_placed    = 1'b1;
            pend_col_span = 1;
            pend_row_span = 1;
            cell_open     = 1'b0;
          end else if (tok >= TOK_COLSPAN_LO && tok <= TOK_COLSPAN_HI) begin
            pend_col_span = clamp_span(tok - TOK_COLSPAN_BIAS);
          end else if (tok >= TOK_ROWSPAN_LO && tok <= TOK_ROWSPAN_HI) begin
            pend_row_span = clamp_span(tok - TOK_ROWSPAN_BIAS);
          end
        end else if (tok == TOK_ROW_END) begin
          for (c = 0; c < NCOLS; c++) begin
            if (rows_held[c] != 0) rows_held[c] = rows_held[c] - 1'b1;
          end
          if (row_pos != CNT_MAX) row_pos++;
          col_pos = 0;
        end else if (tok == TOK_CELL_OPEN) begin
          cell_open     = 1'b1;
          pend_col_span = 1;
          pend_row_span = 1;
        end else if (tok == TOK_EMPTY_CELL) begin
          placed     = place(1, 1, pos);
          has_placed = 1'b1;
        end
      end
      if (tok == TOK_END || is_last) begin
        if (cell_open) begin
          placed     = place(pend_row_span, pend_col_span, pos);
          has_placed = 1'b1;
        end
        if (has_placed) beats_due = {beats_due, placed};
        marker            = '0;
        marker.kind       = KIND_END;
        marker.row_span   = 1;
        marker.col_span   = 1;
        marker.cell_total = cell_count;
        marker.final_res  = 1'b1;
        beats_due = {beats_due, marker};
        clear_grid();
        seen_end = !is_last;
        return;
      end
      if (step_count != CNT_MAX) step_count++;
      if (has_placed) begin
        placed.final_res = 1'b1;
        beats_due = {beats_due, placed};
      end
    endfunction

    function void check_field(string name, logic [CNT_W-1:0] want_v,
                              logic [CNT_W-1:0] got_v);
      if (got_v !== want_v) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (beats_due.size() == 0) begin
        $display("%0t: result beat with nothing expected: %p", $time, got);
        errors++;
        return;
      end
      want = beats_due.pop_front();
      check_field("kind", want.kind, got.kind);
      check_field("cell_row", want.cell_row, got.cell_row);
      check_field("cell_col", want.cell_col, got.cell_col);
      check_field("row_span", want.row_span, got.row_span);
      check_field("col_span", want.col_span, got.col_span);
      check_field("box_index", want.box_index, got.box_index);
      check_field("cell_total", want.cell_total, got.cell_total);
      check_field("col_overflow", want.col_overflow, got.col_overflow);
      check_field("final_res", want.final_res, got.final_res);
    endfunction

    function int unsigned close_out();
      if (beats_due.size() != 0) begin
        $display("%0t: %0d result beats never arrived", $time, beats_due.size());
        errors += beats_due.size();
      end
      return errors;
    endfunction
  endclass

  placement_checker sb = new();
  int unsigned      items_sent = 0;
  bit               send_calm  = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("%0t: run did not finish in time", $time);
    $display("tb: failure");
    $finish;
  end

  task automatic send_token(logic [TOKEN_W-1:0] tok, bit is_last);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 5);
    @(negedge clk_i);
    if (gap != 0) begin
      tok_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    tok_bus.valid <= 1'b1;
    tok_bus.token <= tok;
    tok_bus.last  <= is_last;
    do @(posedge clk_i); while (tok_bus.ready !== 1'b1);
    sb.note_token(tok, is_last);
    items_sent++;
  endtask

  // Stops offering beats and waits until every expected beat has come back, then lets a
  // row-end walk run out, so the block is idle afterwards.
  task automatic drain_results();
    @(negedge clk_i);
    tok_bus.valid <= 1'b0;
    while (sb.beats_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_box_mode(bit mode);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    sb.box_per_step = mode;
  endtask

  task automatic run_directed();
    send_token(6'd0, 1'b0);
    send_token(6'd63, 1'b0);
    send_token(TOK_EMPTY_CELL, 1'b0);
    send_token(TOK_CELL_OPEN, 1'b0);
    send_token(TOK_COLSPAN_LO, 1'b0);
    send_token(TOK_ROWSPAN_HI, 1'b0);
    send_token(TOK_ROW_END, 1'b0);
    send_token(TOK_EMPTY_CELL, 1'b0);
    send_token(TOK_CELL_OPEN, 1'b0);
    send_token(TOK_ATTR_CLOSE, 1'b0);
    send_token(TOK_CELL_END, 1'b0);
    send_token(VOCAB_SIZE, 1'b0);
    send_token(TOK_CELL_OPEN, 1'b0);
    send_token(TOK_COLSPAN_HI, 1'b0);
    send_token(TOK_ROWSPAN_LO, 1'b0);
    send_token(TOK_CELL_END, 1'b0);
    send_token(TOK_ROW_END, 1'b0);
    send_token(TOK_CELL_OPEN, 1'b0);
    // An end token with a cell still open closes it first; later tokens up to the last beat are dropped.
    send_token(TOK_END, 1'b0);
    send_token(6'd5, 1'b0);
    send_token(TOK_END, 1'b0);
    send_token(6'd0, 1'b1);
    send_token(TOK_CELL_OPEN, 1'b0);
    send_token(6'd20, 1'b0);
    send_token(6'd33, 1'b1);
  endtask

  task automatic send_cell(bit wide);
    if ($urandom_range(0, 2) == 0) begin
      send_token(TOK_EMPTY_CELL, 1'b0);
    end else begin
      send_token(TOK_CELL_OPEN, 1'b0);
      if ($urandom_range(0, wide ? 1 : 3) == 0) begin
        send_token(TOKEN_W'(TOK_COLSPAN_LO + $urandom_range(0, wide ? 18 : 3)), 1'b0);
      end
      if ($urandom_range(0, 3) == 0) begin
        send_token(TOKEN_W'(TOK_ROWSPAN_LO +
                            $urandom_range(0, $urandom_range(0, 1) ? 3 : 18)), 1'b0);
      end
      if ($urandom_range(0, 19) == 0) send_token(TOKEN_W'($urandom_range(0, 63)), 1'b0);
      if ($urandom_range(0, 1)) begin
        send_token(TOK_ATTR_CLOSE, 1'b0);
        send_token(TOK_CELL_END, 1'b0);
      end else begin
        send_token(TOK_CELL_END, 1'b0);
      end
    end
  endtask

  task automatic send_table();
    int unsigned nrows;
    int unsigned ncells;
    int unsigned r;
    int unsigned k;
    bit          wide;
    wide  = ($urandom_range(0, 4) == 0);
    nrows = $urandom_range(1, wide ? 3 : 6);
    for (r = 0; r < nrows; r++) begin
      ncells = $urandom_range(0, wide ? 14 : 6);
      for (k = 0; k < ncells; k++) send_cell(wide);
      if (r + 1 < nrows || $urandom_range(0, 1)) send_token(TOK_ROW_END, 1'b0);
    end
    case ($urandom_range(0, 3))
      0: begin
        send_token(TOK_END, 1'b0);
        repeat ($urandom_range(0, 3)) send_token(TOKEN_W'($urandom_range(0, 63)), 1'b0);
        send_token(TOKEN_W'($urandom_range(0, 63)), 1'b1);
      end
      1: begin
        send_token(TOK_END, 1'b1);
      end
      2: begin
        // The last beat arrives while a cell is still collecting its spans.
        send_token(TOK_CELL_OPEN, 1'b0);
        send_token(TOKEN_W'(TOK_COLSPAN_LO + $urandom_range(0, 18)), 1'b0);
        send_token(TOKEN_W'($urandom_range(0, 63)), 1'b1);
      end
      default: begin
        send_token(TOKEN_W'($urandom_range(0, 63)), 1'b1);
      end
    endcase
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4)) begin
      send_token(TOKEN_W'($urandom_range(0, 63)), $urandom_range(0, 15) == 0);
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    int unsigned taken;
    bit          calm;
    bit          held_long;
    res_t        got;
    taken         = 0;
    calm          = 1'b0;
    held_long     = 1'b0;
    res_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 31) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, 5);
      // One long hold-off so that the block backs up into its token input.
      if (!held_long && taken == HOLD_AT_BEAT) begin
        held_long = 1'b1;
        stall     = LONG_HOLD;
      end
      @(negedge clk_i);
      if (stall != 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk_i); while (res_bus.valid !== 1'b1);
      got.kind         = res_bus.kind;
      got.cell_row     = res_bus.cell_row;
      got.cell_col     = res_bus.cell_col;
      got.row_span     = res_bus.row_span;
      got.col_span     = res_bus.col_span;
      got.box_index    = res_bus.box_index;
      got.cell_total   = res_bus.cell_total;
      got.col_overflow = res_bus.col_overflow;
      got.final_res    = res_bus.final_res;
      sb.check_result(got);
      taken++;
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned target;
    bit          paused;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = 1'b0;
    tok_bus.valid = 1'b0;
    tok_bus.token = '0;
    tok_bus.last  = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    drain_results();
    for (phase = 0; phase < 4; phase++) begin
      write_box_mode(phase[0]);
      target = items_sent + PHASE_ITEMS;
      paused = 1'b0;
      while (items_sent < target) begin
        if ($urandom_range(0, 4) == 0) begin
          send_noise();
        end else begin
          send_table();
        end
        if (phase == 1 && !paused && items_sent + PHASE_ITEMS / 2 > target) begin
          drain_results();
          paused = 1'b1;
        end
      end
      drain_results();
    end
    if (sb.close_out() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/ttcp_pkg.sv
rtl/ttcp_if.sv
rtl/ttcp_held_mem.sv
rtl/ttcp_out_reg.sv
rtl/ttcp_ctrl.sv
rtl/table_token_cell_placer_unit.sv
bench/tb_top.sv
